### hdl/weather_frame_parser_unit_defines.svh
// Assertion helpers used by the parser unit.
`ifndef WEATHER_FRAME_PARSER_UNIT_DEFINES_SVH
`define WEATHER_FRAME_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WFP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("weather frame parser check failed");

// Next-cycle implication, checked outside reset.
`define WFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("weather frame parser check failed");

`endif

### hdl/wfp_pkg.sv
package wfp_pkg;

    localparam int FRAME_DEPTH = 16;
    localparam int IDX_W       = $clog2(FRAME_DEPTH);
    localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);

    localparam logic [7:0] SYNC_BYTE   = 8'hFF;
    localparam logic [7:0] SUM_SEED    = 8'hFE;  // 0xFF + 0xFF mod 256
    localparam logic [7:0] TYPE_THB    = 8'h06;
    localparam logic [7:0] TYPE_WIND   = 8'h00;
    localparam logic [7:0] TYPE_OUTDOOR = 8'h03;
    localparam logic [7:0] TYPE_CLOCK  = 8'h0F;

    localparam logic [15:0] IDLE_LIMIT_RST = 16'd500;

    localparam int PRESS_OFS   = 856;
    localparam int YEAR_BASE   = 2000;
    localparam int WIND_SCALE  = 36;
    localparam int WIND_ROUND  = 5;
    localparam int SECTOR_BIAS = 22;
    // x / 10 == (x * 52429) >> 19 for every 16-bit x
    localparam int RECIP10     = 52429;
    localparam int RECIP10_SH  = 19;
    // y / 45 == (y * 1457) >> 16 for y below 2259
    localparam int RECIP45     = 1457;
    localparam int RECIP45_SH  = 16;

    typedef enum logic [1:0] {
        ST_SYNC1,
        ST_SYNC2,
        ST_TYPE,
        ST_COLLECT
    } t_hunt;

    typedef enum logic [1:0] {
        REC_INDOOR  = 2'd0,
        REC_WIND    = 2'd1,
        REC_OUTDOOR = 2'd2,
        REC_CLOCK   = 2'd3
    } t_rec_kind;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        t_rec_kind   record_kind;
        logic [14:0] temp_tenths;
        logic [7:0]  humidity_pct;
        logic [10:0] pressure_hpa;
        logic [12:0] wind_kmh_tenths;
        logic [10:0] wind_angle;
        logic [2:0]  wind_sector;
        logic [7:0]  minute_val;
        logic [7:0]  hour_val;
        logic [7:0]  day_val;
        logic [7:0]  month_val;
        logic [11:0] year_val;
    } t_out_item;

    // Completed frame as handed to the decoder.
    typedef struct packed {
        t_rec_kind   kind;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  b4;
        logic [7:0]  b5;
        logic [7:0]  b6;
        logic [15:0] wind_x;   // speed digits * 36 + 5
        logic [10:0] angle;
    } t_snap;

    function automatic logic [7:0] bcd2(input logic [7:0] b);
        logic [7:0] hi;
        hi = {4'd0, b[7:4]};
        return 8'((hi << 3) + (hi << 1) + {4'd0, b[3:0]});
    endfunction

endpackage

### hdl/wfp_decode.sv
module wfp_decode (
    input  wfp_pkg::t_snap     i_snap,
    output wfp_pkg::t_out_item o_rec
);

    logic [31:0] wind_prod;
    logic [10:0] sector_in;
    logic [21:0] sector_prod;

    assign wind_prod   = 32'(i_snap.wind_x) * 32'(wfp_pkg::RECIP10);
    assign sector_in   = i_snap.angle + 11'(wfp_pkg::SECTOR_BIAS);
    assign sector_prod = 22'(sector_in) * 22'(wfp_pkg::RECIP45);

    always_comb begin
        o_rec             = '0;
        o_rec.record_kind = i_snap.kind;
        case (i_snap.kind)
            wfp_pkg::REC_INDOOR, wfp_pkg::REC_OUTDOOR: begin
                o_rec.temp_tenths  = 15'(i_snap.b3) * 15'd100
                                   + 15'(wfp_pkg::bcd2(i_snap.b2));
                o_rec.humidity_pct = wfp_pkg::bcd2(i_snap.b4);
                if (i_snap.kind == wfp_pkg::REC_INDOOR) begin
                    o_rec.pressure_hpa = 11'(i_snap.b6) + 11'(wfp_pkg::PRESS_OFS);
                end
            end
            wfp_pkg::REC_WIND: begin
                o_rec.wind_kmh_tenths = wind_prod[wfp_pkg::RECIP10_SH +: 13];
                o_rec.wind_angle      = i_snap.angle;
                o_rec.wind_sector     = sector_prod[wfp_pkg::RECIP45_SH +: 3];
            end
            default: begin
                o_rec.minute_val = wfp_pkg::bcd2(i_snap.b1);
                o_rec.hour_val   = wfp_pkg::bcd2(i_snap.b2);
                o_rec.day_val    = wfp_pkg::bcd2(i_snap.b3);
                o_rec.month_val  = wfp_pkg::bcd2(i_snap.b4);
                o_rec.year_val   = 12'(wfp_pkg::bcd2(i_snap.b5))
                                 + 12'(wfp_pkg::YEAR_BASE);
            end
        endcase
    end

endmodule

### hdl/weather_frame_parser_unit.sv
// Weather station serial frame decoder. Each input transfer is a received byte
// or an idle tick; the unit takes one transfer every clock cycle while input
// ready is high, with the sync hunt, frame store and running checksum updated
// at the transfer itself. When the last byte of a frame with a good checksum
// arrives, the frame is latched into a snapshot register, and from there it is
// decoded into the output register once that register is free. Bad checksums,
// unknown type bytes and idle timeouts produce no record and restart the hunt.
// The snapshot register and the output register form a two-entry queue: input
// ready drops only when both hold a record and the output side is stalled.
// i_cfg_data goes to the idle limit on any non-reset cycle with i_cfg_we high.
`include "weather_frame_parser_unit_defines.svh"

module weather_frame_parser_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte / idle tick stream
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  wfp_pkg::t_in_item  i_in_data,
    // decoded records
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output wfp_pkg::t_out_item o_out_data,
    // idle limit register
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data
);

    localparam int CNT_W = wfp_pkg::CNT_W;
    localparam int IDX_W = wfp_pkg::IDX_W;
    localparam logic [CNT_W-1:0] LEN_THB   = CNT_W'(12);
    localparam logic [CNT_W-1:0] LEN_WIND  = CNT_W'(9);
    localparam logic [CNT_W-1:0] LEN_SHORT = CNT_W'(7);

    // parser state
    wfp_pkg::t_hunt      r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [15:0]         r_idle, n_idle;
    logic [15:0]         r_limit;
    logic [7:0]          r_sum, n_sum;
    logic [CNT_W-1:0]    r_len, n_len;
    wfp_pkg::t_rec_kind  r_kind, n_kind;
    logic [7:0]          r_frame [wfp_pkg::FRAME_DEPTH];

    // snapshot and output stages
    logic                r_snap_v, n_snap_v;
    wfp_pkg::t_snap      r_snap, n_snap;
    logic                r_out_v, n_out_v;
    wfp_pkg::t_out_item  r_out;
    wfp_pkg::t_out_item  dec_rec;

    logic                in_xfer;
    logic                out_free;
    logic                snap_move;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    logic                frame_good;
    logic [CNT_W-1:0]    cnt_inc;
    logic [7:0]          c;
    logic [10:0]         wind_digits;

    assign c         = i_in_data.rx_byte;
    assign out_free  = !r_out_v || i_out_ready;
    assign snap_move = r_snap_v && out_free;
    assign o_in_ready = !r_snap_v || out_free;
    assign in_xfer   = i_in_valid && o_in_ready;
    assign cnt_inc   = r_cnt + CNT_W'(1);

    // Parser: idle timeout, sync hunt, type decode, byte collection and checksum.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_idle     = r_idle;
        n_sum      = r_sum;
        n_len      = r_len;
        n_kind     = r_kind;
        wr_en      = 1'b0;
        wr_idx     = r_cnt[IDX_W-1:0];
        frame_good = 1'b0;
        if (in_xfer) begin
            if (i_in_data.kind) begin
                // idle tick: time out the hunt or keep counting
                if (r_idle >= r_limit) begin
                    n_state = wfp_pkg::ST_SYNC1;
                    n_cnt   = '0;
                    n_idle  = '0;
                end else begin
                    n_idle = r_idle + 16'd1;
                end
            end else begin
                n_idle = '0;
                case (r_state)
                    wfp_pkg::ST_SYNC1: begin
                        if (c == wfp_pkg::SYNC_BYTE) begin
                            n_state = wfp_pkg::ST_SYNC2;
                        end
                    end
                    wfp_pkg::ST_SYNC2: begin
                        n_state = (c == wfp_pkg::SYNC_BYTE) ? wfp_pkg::ST_TYPE
                                                            : wfp_pkg::ST_SYNC1;
                    end
                    wfp_pkg::ST_TYPE: begin
                        // store type byte at slot zero and start the sum
                        n_state = wfp_pkg::ST_COLLECT;
                        n_cnt   = CNT_W'(1);
                        n_sum   = wfp_pkg::SUM_SEED + c;
                        wr_en   = 1'b1;
                        wr_idx  = '0;
                        case (c)
                            wfp_pkg::TYPE_THB: begin
                                n_len  = LEN_THB;
                                n_kind = wfp_pkg::REC_INDOOR;
                            end
                            wfp_pkg::TYPE_WIND: begin
                                n_len  = LEN_WIND;
                                n_kind = wfp_pkg::REC_WIND;
                            end
                            wfp_pkg::TYPE_OUTDOOR: begin
                                n_len  = LEN_SHORT;
                                n_kind = wfp_pkg::REC_OUTDOOR;
                            end
                            wfp_pkg::TYPE_CLOCK: begin
                                n_len  = LEN_SHORT;
                                n_kind = wfp_pkg::REC_CLOCK;
                            end
                            default: begin
                                // unknown type: drop and hunt again
                                n_state = wfp_pkg::ST_SYNC1;
                                n_cnt   = '0;
                                n_sum   = r_sum;
                                wr_en   = 1'b0;
                            end
                        endcase
                    end
                    wfp_pkg::ST_COLLECT: begin
                        wr_en = (r_cnt < CNT_W'(wfp_pkg::FRAME_DEPTH));
                        n_cnt = cnt_inc;
                        n_sum = r_sum + c;
                        if (cnt_inc >= r_len) begin
                            // last byte carries the checksum
                            n_state    = wfp_pkg::ST_SYNC1;
                            n_cnt      = '0;
                            frame_good = (r_sum == c);
                        end
                    end
                    default: begin
                        n_state = wfp_pkg::ST_SYNC1;
                        n_cnt   = '0;
                    end
                endcase
            end
        end
    end

    // Snapshot of the finished frame, with the wind pre-products.
    assign wind_digits = 11'(r_frame[4][7:4]) * 11'd100
                       + 11'(r_frame[4][3:0]) * 11'd10
                       + 11'(r_frame[3][7:4]);

    always_comb begin
        n_snap        = r_snap;
        n_snap_v      = r_snap_v;
        if (snap_move) begin
            n_snap_v = 1'b0;
        end
        if (frame_good) begin
            n_snap_v      = 1'b1;
            n_snap.kind   = r_kind;
            n_snap.b1     = r_frame[1];
            n_snap.b2     = r_frame[2];
            n_snap.b3     = r_frame[3];
            n_snap.b4     = r_frame[4];
            n_snap.b5     = r_frame[5];
            n_snap.b6     = r_frame[6];
            n_snap.wind_x = 16'(wind_digits) * 16'(wfp_pkg::WIND_SCALE)
                          + 16'(wfp_pkg::WIND_ROUND);
            n_snap.angle  = 11'(r_frame[3][3:0]) * 11'd100
                          + 11'(wfp_pkg::bcd2(r_frame[2]));
        end
    end

    wfp_decode u_decode (
        .i_snap (r_snap),
        .o_rec  (dec_rec)
    );

    // Output register: load on snapshot advance, drop once taken.
    always_comb begin
        n_out_v = r_out_v;
        if (snap_move) begin
            n_out_v = 1'b1;
        end else if (i_out_ready) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wfp_pkg::ST_SYNC1;
            r_cnt    <= '0;
            r_idle   <= '0;
            r_limit  <= wfp_pkg::IDLE_LIMIT_RST;
            r_snap_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_idle   <= n_idle;
            r_snap_v <= n_snap_v;
            r_out_v  <= n_out_v;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_len  <= n_len;
        r_kind <= n_kind;
        r_snap <= n_snap;
        if (wr_en) begin
            r_frame[wr_idx] <= c;
        end
        if (snap_move) begin
            r_out <= dec_rec;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // Checks
    `WFP_ASSERT_IMPL(a_collect_count, i_clk, i_rst_n,
        r_state == wfp_pkg::ST_COLLECT, r_cnt != '0 && r_cnt < r_len)
    `WFP_ASSERT_IMPL(a_hunt_count_clear, i_clk, i_rst_n,
        r_state != wfp_pkg::ST_COLLECT, r_cnt == '0)
    `WFP_ASSERT_NEXT(a_out_from_snap, i_clk, i_rst_n,
        !r_snap_v && (!r_out_v || i_out_ready), !o_out_valid)

endmodule
